FILE: rtl/pv2_pkg.sv
package pv2_pkg;

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_ENDPOINT = 2'd1;
   localparam logic [1:0] KIND_STATUS   = 2'd2;

   localparam logic [2:0] ERR_SIGNATURE = 3'd0;
   localparam logic [2:0] ERR_VERSION   = 3'd1;
   localparam logic [2:0] ERR_COMMAND   = 3'd2;
   localparam logic [2:0] ERR_FAMILY    = 3'd3;
   localparam logic [2:0] ERR_SHORT_ADR = 3'd4;
   localparam logic [2:0] ERR_SHORT_TLV = 3'd5;
   localparam logic [2:0] ERR_TLV_VALUE = 3'd6;
   localparam logic [2:0] ERR_TLS_TLV   = 3'd7;

   localparam logic [7:0] TLV_TYPE_TLS = 8'h20;

   // one result beat, packed as the output tdata fields
   typedef struct packed {
      logic [2:0] error_code;
      logic       failed;
      logic       client_tls;
      logic       section_done;
      logic [1:0] address_family;
      logic [7:0] endpoint_offset;
      logic [7:0] value;
      logic [1:0] kind;
   } result_type;

   function automatic logic [7:0] sig_byte(input logic [3:0] p);
      case (p)
         4'd0, 4'd2:        sig_byte = 8'h0D;
         4'd1, 4'd3:        sig_byte = 8'h0A;
         4'd4:              sig_byte = 8'h00;
         4'd5:              sig_byte = 8'h0D;
         4'd6, 4'd11:       sig_byte = 8'h0A;
         4'd7:              sig_byte = 8'h51;
         4'd8:              sig_byte = 8'h55;
         4'd9:              sig_byte = 8'h49;
         4'd10:             sig_byte = 8'h54;
         default:           sig_byte = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] fam_min(input logic [1:0] f);
      case (f)
         2'd1:    fam_min = 8'd12;
         2'd2:    fam_min = 8'd36;
         2'd3:    fam_min = 8'd216;
         default: fam_min = 8'd0;
      endcase
   endfunction

endpackage

FILE: rtl/pv2_front.sv
module pv2_front
   import pv2_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tls_enable,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_start,
   output logic       out_valid,
   output result_type out_res,
   input  logic       out_space
);

   localparam logic [1:0] PH_HEADER    = 2'd0;
   localparam logic [1:0] PH_SECTION   = 2'd1;
   localparam logic [1:0] PH_CONNECTED = 2'd2;
   localparam logic [1:0] PH_FAILED    = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic        cmd_ff, cmd_in;
   logic [1:0]  fam_ff, fam_in;
   logic [15:0] len_ff, len_in;
   logic [1:0]  step_ff, step_in;
   logic        istls_ff, istls_in;
   logic [15:0] vlen_ff, vlen_in;
   logic [15:0] vcnt_ff, vcnt_in;
   logic        seen_ff, seen_in;

   // effective state after an optional restart
   logic [1:0]  ph;
   logic [15:0] pos, len, vlen, vcnt;
   logic        cmd, istls, seen;
   logic [1:0]  fam, step;
   logic [15:0] rem, full_len, vcnt_inc;
   logic        emit;
   result_type  res;

   assign in_ready = out_space;

   // per-byte classification
   always_comb begin
      ph    = in_start ? PH_HEADER : phase_ff;
      pos   = in_start ? 16'd0 : pos_ff;
      cmd   = in_start ? 1'b0 : cmd_ff;
      fam   = in_start ? 2'd0 : fam_ff;
      len   = in_start ? 16'd0 : len_ff;
      step  = in_start ? 2'd0 : step_ff;
      istls = in_start ? 1'b0 : istls_ff;
      vlen  = in_start ? 16'd0 : vlen_ff;
      vcnt  = in_start ? 16'd0 : vcnt_ff;
      seen  = in_start ? 1'b0 : seen_ff;
      phase_in = ph; pos_in = pos; cmd_in = cmd; fam_in = fam; len_in = len;
      step_in = step; istls_in = istls; vlen_in = vlen; vcnt_in = vcnt;
      seen_in = seen;
      rem      = len - pos;
      full_len = {len[15:8], in_byte};
      vcnt_inc = vcnt + 16'd1;
      emit = 1'b0;
      res  = '0;
      res.kind = KIND_STATUS;
      unique case (ph)
         PH_FAILED: ;
         PH_CONNECTED: begin
            emit = 1'b1;
            res.kind = KIND_PAYLOAD;
            res.value = in_byte;
            res.client_tls = seen;
         end
         PH_HEADER: begin
            pos_in = pos + 16'd1;
            if (pos < 16'd12) begin
               if (in_byte != sig_byte(pos[3:0])) begin
                  emit = 1'b1; res.failed = 1'b1; res.error_code = ERR_SIGNATURE;
               end
            end else if (pos == 16'd12) begin
               if (in_byte[7:4] != 4'h2) begin
                  emit = 1'b1; res.failed = 1'b1; res.error_code = ERR_VERSION;
               end else if (in_byte[3:0] > 4'h1) begin
                  emit = 1'b1; res.failed = 1'b1; res.error_code = ERR_COMMAND;
               end else begin
                  cmd_in = in_byte[0];
               end
            end else if (pos == 16'd13) begin
               if (cmd) begin
                  if (in_byte == 8'h11) fam_in = 2'd1;
                  else if (in_byte == 8'h21) fam_in = 2'd2;
                  else if (in_byte == 8'h31) fam_in = 2'd3;
                  else begin
                     emit = 1'b1; res.failed = 1'b1; res.error_code = ERR_FAMILY;
                  end
               end
            end else if (pos == 16'd14) begin
               len_in = {in_byte, 8'h00};
            end else begin
               len_in = full_len;
               pos_in = 16'd0;
               step_in = 2'd0;
               if (cmd && full_len < {8'h00, fam_min(fam)}) begin
                  emit = 1'b1; res.failed = 1'b1; res.error_code = ERR_SHORT_ADR;
               end else if (full_len == 16'd0) begin
                  phase_in = PH_CONNECTED;
                  emit = 1'b1; res.section_done = 1'b1; res.client_tls = seen;
               end else begin
                  phase_in = PH_SECTION;
               end
            end
         end
         default: begin
            pos_in = pos + 16'd1;
            if (cmd) begin
               if (pos < {8'h00, fam_min(fam)}) begin
                  emit = 1'b1;
                  res.kind = KIND_ENDPOINT;
                  res.value = in_byte;
                  res.endpoint_offset = pos[7:0];
               end else begin
                  case (step)
                     2'd0: begin
                        if (rem < 16'd3) begin
                           emit = 1'b1; res.failed = 1'b1;
                           res.error_code = ERR_SHORT_TLV;
                        end
                        istls_in = (in_byte == TLV_TYPE_TLS);
                        step_in = 2'd1;
                     end
                     2'd1: begin
                        vlen_in = {in_byte, 8'h00};
                        step_in = 2'd2;
                     end
                     2'd2: begin
                        vlen_in = {vlen[15:8], in_byte};
                        if (rem - 16'd1 < {vlen[15:8], in_byte}) begin
                           emit = 1'b1; res.failed = 1'b1;
                           res.error_code = ERR_TLV_VALUE;
                        end else if (istls && {vlen[15:8], in_byte} < 16'd5) begin
                           emit = 1'b1; res.failed = 1'b1;
                           res.error_code = ERR_TLS_TLV;
                        end
                        vcnt_in = 16'd0;
                        step_in = ({vlen[15:8], in_byte} != 16'd0) ? 2'd3 : 2'd0;
                     end
                     default: begin
                        if (istls && vcnt == 16'd0 && tls_enable && in_byte[0])
                           seen_in = 1'b1;
                        vcnt_in = vcnt_inc;
                        if (vcnt_inc >= vlen) step_in = 2'd0;
                     end
                  endcase
               end
            end
            if (!res.failed && pos + 16'd1 == len) begin
               phase_in = PH_CONNECTED;
               emit = 1'b1;
               res.section_done = 1'b1;
               res.client_tls = seen_in;
            end
         end
      endcase
      if (res.failed) begin
         phase_in = PH_FAILED;
         res.address_family = fam_in;
      end else begin
         res.address_family = fam_in;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; pos_ff <= '0; cmd_ff <= 1'b0; fam_ff <= '0;
         len_ff <= '0; step_ff <= '0; istls_ff <= 1'b0; vlen_ff <= '0;
         vcnt_ff <= '0; seen_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         phase_ff <= phase_in; pos_ff <= pos_in; cmd_ff <= cmd_in; fam_ff <= fam_in;
         len_ff <= len_in; step_ff <= step_in; istls_ff <= istls_in;
         vlen_ff <= vlen_in; vcnt_ff <= vcnt_in; seen_ff <= seen_in;
      end
   end

   assign out_valid = in_valid && in_ready && emit;
   assign out_res   = res;

endmodule

FILE: rtl/pv2_queue.sv
module pv2_queue
   import pv2_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_valid,
   input  result_type wr_data,
   output logic       wr_space,
   output logic       rd_valid,
   output result_type rd_data,
   input  logic       rd_ready
);

   result_type  slot_ff [2];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  count_ff;
   logic        do_wr, do_rd;

   assign wr_space = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = slot_ff[rptr_ff];
   assign do_wr    = wr_valid && wr_space;
   assign do_rd    = rd_valid && rd_ready;

   // two-entry queue storage
   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wptr_ff] <= wr_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0; rptr_ff <= 1'b0; count_ff <= 2'd0;
      end else begin
         if (do_wr) wptr_ff <= ~wptr_ff;
         if (do_rd) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + {1'b0, do_wr} - {1'b0, do_rd};
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !do_rd) |=> count_ff == 2'd2) else $error("full lost entry");
   a_empty_hold: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 && !wr_valid) |=> !rd_valid) else $error("invented entry");
`endif

endmodule

FILE: rtl/proxy_v2_header_parser.sv
// channel  | ports      | tdata (low up)                         | tuser
// request  | req_t*     | stream_byte                            | starts_connection
// response | rsp_t*     | kind,value,endpoint_offset,family,     | -
//          |            | section_done,client_tls,failed,error   |
// csr      | csr_wr_*   | tls_mark_enable                        | -
// one byte taken per clock unless the queue is full; results are registered in the queue
// the front parser classifies each byte in its accept cycle; a two-entry queue feeds rsp
// req_tready drops only while the queue is full
// reset is synchronous: parser goes to header wait, tls_mark_enable to 1
module proxy_v2_header_parser
   import pv2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // stream_byte
   input  logic        req_tuser,   // starts_connection
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // kind,value,endpoint_offset,address_family,
                                    // section_done,client_tls,failed,error_code
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // tls_mark_enable
);

   logic       tls_en_ff;
   logic       f_valid, q_space;
   result_type f_res, q_res;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) tls_en_ff <= 1'b1;
      else if (csr_wr_en) tls_en_ff <= csr_wr_data;
   end

   pv2_front u_front (
      .clock, .reset, .tls_enable(tls_en_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata), .in_start(req_tuser),
      .out_valid(f_valid), .out_res(f_res), .out_space(q_space)
   );

   pv2_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_data(f_res), .wr_space(q_space),
      .rd_valid(rsp_tvalid), .rd_data(q_res), .rd_ready(rsp_tready)
   );

   assign rsp_tdata = {6'd0, q_res};

endmodule

FILE: tb/sv/tb.sv
module tb;
   import pv2_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   // parser phases
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_SECTION = 2'd1;
   localparam logic [1:0] PH_CONNECTED = 2'd2;
   localparam logic [1:0] PH_FAILED = 2'd3;

   proxy_v2_header_parser dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // predictor state
   logic        mark_en;
   logic [1:0]  ph;
   logic [15:0] pos;
   logic        cmd_proxy;
   logic [1:0]  fam;
   logic [15:0] sec_len;
   logic [1:0]  tstep;
   logic        t_is_tls;
   logic [15:0] t_len;
   logic [15:0] t_cnt;
   logic        tls_flag;

   result_type  expected_beats[$];
   int          mismatches = 0;
   int          sent_bytes = 0;
   bit          stall_rx = 1'b0;
   int          gap_rx_max = 3;
   int          gap_tx_max = 3;

   function automatic logic [7:0] sigb(input int p);
      logic [7:0] s[12];
      s = '{8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D, 8'h0A, 8'h51, 8'h55, 8'h49,
            8'h54, 8'h0A};
      return s[p];
   endfunction

   function automatic logic [15:0] min_len(input logic [1:0] f);
      case (f)
         2'd1: return 16'd12;
         2'd2: return 16'd36;
         2'd3: return 16'd216;
         default: return 16'd0;
      endcase
   endfunction

   task automatic clear_parser();
      ph = PH_HEADER; pos = 0; cmd_proxy = 0; fam = 0; sec_len = 0; tstep = 0;
      t_is_tls = 0; t_len = 0; t_cnt = 0; tls_flag = 0;
   endtask

   task automatic push_beat(input logic [1:0] k, input logic [7:0] v,
                            input logic [7:0] off, input logic done,
                            input logic tls, input logic bad, input logic [2:0] code);
      result_type r;
      r.kind = k; r.value = v; r.endpoint_offset = off; r.address_family = fam;
      r.section_done = done; r.client_tls = tls; r.failed = bad; r.error_code = code;
      expected_beats.push_back(r);
   endtask

   task automatic parse_fail(input logic [2:0] code);
      ph = PH_FAILED;
      push_beat(KIND_STATUS, 0, 0, 0, 0, 1, code);
   endtask

   // byte-level model of the parser
   task automatic predict_byte(input logic [7:0] b, input logic start);
      logic [31:0] p;
      logic [31:0] rem;
      logic        last;
      logic [1:0]  k;
      logic [7:0]  v;
      logic [7:0]  off;
      if (start) clear_parser();
      if (ph == PH_FAILED) return;
      if (ph == PH_CONNECTED) begin
         push_beat(KIND_PAYLOAD, b, 0, 0, tls_flag, 0, 0);
         return;
      end
      if (ph == PH_HEADER) begin
         p = pos;
         if (p < 12) begin
            if (b != sigb(p)) begin parse_fail(ERR_SIGNATURE); return; end
         end else if (p == 12) begin
            if ((b & 8'hF0) != 8'h20) begin parse_fail(ERR_VERSION); return; end
            if ((b & 8'h0F) > 8'h01) begin parse_fail(ERR_COMMAND); return; end
            cmd_proxy = b[0];
         end else if (p == 13) begin
            if (cmd_proxy) begin
               if (b == 8'h11) fam = 1;
               else if (b == 8'h21) fam = 2;
               else if (b == 8'h31) fam = 3;
               else begin parse_fail(ERR_FAMILY); return; end
            end
         end else if (p == 14) begin
            sec_len = {b, 8'h00};
         end else begin
            sec_len = sec_len | b;
            if (cmd_proxy && sec_len < min_len(fam)) begin
               parse_fail(ERR_SHORT_ADR); return;
            end
            pos = 0; tstep = 0;
            if (sec_len == 0) begin
               ph = PH_CONNECTED;
               push_beat(KIND_STATUS, 0, 0, 1, tls_flag, 0, 0);
               return;
            end
            ph = PH_SECTION;
            return;
         end
         pos = p + 1;
         return;
      end
      // section bytes
      p = pos;
      last = (p + 1 == sec_len);
      k = KIND_STATUS; v = 0; off = 0;
      if (cmd_proxy) begin
         if (p < min_len(fam)) begin
            k = KIND_ENDPOINT; v = b; off = p[7:0];
         end else begin
            rem = sec_len - p;
            case (tstep)
               2'd0: begin
                  if (rem < 3) begin parse_fail(ERR_SHORT_TLV); return; end
                  t_is_tls = (b == TLV_TYPE_TLS);
                  tstep = 1;
               end
               2'd1: begin
                  t_len = {b, 8'h00};
                  tstep = 2;
               end
               2'd2: begin
                  t_len = t_len | b;
                  if (rem - 1 < t_len) begin parse_fail(ERR_TLV_VALUE); return; end
                  if (t_is_tls && t_len < 5) begin parse_fail(ERR_TLS_TLV); return; end
                  t_cnt = 0;
                  tstep = (t_len != 0) ? 2'd3 : 2'd0;
               end
               default: begin
                  if (t_is_tls && t_cnt == 0 && mark_en && b[0]) tls_flag = 1;
                  t_cnt = t_cnt + 1;
                  if (t_cnt >= t_len) tstep = 0;
               end
            endcase
         end
      end
      pos = p + 1;
      if (last) begin
         ph = PH_CONNECTED;
         push_beat(k, v, off, 1, tls_flag, 0, 0);
      end else if (k == KIND_ENDPOINT) begin
         push_beat(k, v, off, 0, 0, 0, 0);
      end
   endtask

   function automatic int pick_gap(input int maxg);
      if (maxg == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
      return $urandom_range(0, maxg);
   endfunction

   // send one byte, predicting at acceptance; valid stays up between back-to-back beats
   task automatic send_byte(input logic [7:0] b, input logic start);
      int g;
      g = pick_gap(gap_tx_max);
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      predict_byte(b, start);
      sent_bytes++;
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0 && n < 200000) begin
         @(posedge clock); n++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mark(input logic en);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= en;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mark_en = en;
   endtask

   // build one well-formed preamble (tlvs for proxy, random filler for local) and a bit of payload
   task automatic send_frame(input int cmd, input int f, input int tlv_n,
                             input int pay_n, input bit tls_bit);
      logic [7:0] hdr[$];
      int alen;
      int len;
      int i;
      int j;
      int vl;
      logic [7:0] body[$];
      alen = (cmd == 0) ? 0 : (f == 1 ? 12 : (f == 2 ? 36 : 216));
      for (i = 0; i < alen; i++) body.push_back(8'($urandom));
      if (cmd == 0) for (i = 0; i < tlv_n * 3; i++) body.push_back(8'($urandom));
      else for (i = 0; i < tlv_n; i++) begin
         vl = $urandom_range(0, 7);
         if ($urandom_range(0, 1)) begin
            if (vl < 5) vl = 5;
            body.push_back(TLV_TYPE_TLS);
         end else body.push_back(8'($urandom_range(0, 255)) | 8'h01);
         body.push_back(8'h00);
         body.push_back(vl[7:0]);
         for (j = 0; j < vl; j++)
            body.push_back(j == 0 ? {7'($urandom_range(0, 127)), tls_bit} : 8'($urandom));
      end
      len = body.size();
      for (i = 0; i < 12; i++) hdr.push_back(sigb(i));
      hdr.push_back(8'h20 | cmd[7:0]);
      hdr.push_back(cmd == 0 ? 8'($urandom) :
                    (f == 1 ? 8'h11 : (f == 2 ? 8'h21 : 8'h31)));
      hdr.push_back(len[15:8]);
      hdr.push_back(len[7:0]);
      foreach (hdr[i]) send_byte(hdr[i], i == 0);
      foreach (body[i]) send_byte(body[i], 1'b0);
      for (i = 0; i < pay_n; i++) send_byte(8'($urandom), 1'b0);
   endtask

   // header with one field corrupted at position p
   task automatic send_broken(input int p, input logic [7:0] b, input logic [15:0] len,
                              input logic [7:0] famb);
      int i;
      logic [7:0] x;
      for (i = 0; i < 16; i++) begin
         if (i < 12) x = sigb(i);
         else if (i == 12) x = 8'h21;
         else if (i == 13) x = famb;
         else if (i == 14) x = len[15:8];
         else x = len[7:0];
         if (i == p) x = b;
         send_byte(x, i == 0);
      end
      for (i = 0; i < 3; i++) send_byte(8'($urandom), 1'b0);
   endtask

   // truncated tlv cases in an ipv4 section
   task automatic send_tlv_case(input logic [7:0] t, input logic [15:0] vl,
                                input int extra);
      int i;
      logic [15:0] len;
      len = 16'(12 + 3 + extra);
      for (i = 0; i < 12; i++) send_byte(sigb(i), i == 0);
      send_byte(8'h21, 0); send_byte(8'h11, 0);
      send_byte(len[15:8], 0); send_byte(len[7:0], 0);
      for (i = 0; i < 12; i++) send_byte(8'($urandom), 0);
      send_byte(t, 0); send_byte(vl[15:8], 0); send_byte(vl[7:0], 0);
      for (i = 0; i < extra + 2; i++) send_byte(8'($urandom), 0);
   endtask

   task automatic test_directed();
      send_frame(0, 0, 0, 2, 0);        // empty local section
      send_frame(0, 0, 2, 2, 0);        // local skips its length
      send_frame(1, 1, 1, 3, 1);
      send_frame(1, 2, 1, 2, 1);
      send_frame(1, 3, 0, 1, 0);
      send_broken(3, 8'hFF, 16'd12, 8'h11);
      send_broken(12, 8'h31, 16'd12, 8'h11);
      send_broken(12, 8'h2F, 16'd12, 8'h11);
      send_broken(13, 8'h12, 16'd12, 8'h11);
      send_broken(15, 8'd11, 16'd0, 8'h11);
      send_tlv_case(8'h05, 16'd200, 0);  // value overruns
      send_tlv_case(TLV_TYPE_TLS, 16'd2, 2); // tls too short
      send_tlv_case(8'h05, 16'd0, 1);    // short tlv header after empty tlv
      send_byte(8'hFF, 0);
   endtask

   // random traffic until about n more bytes have been sent
   task automatic test_random(input int n);
      int first;
      int r;
      first = sent_bytes;
      while (sent_bytes - first < n) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            send_frame($urandom_range(0, 1), $urandom_range(1, 3) == 3 &&
                       $urandom_range(0, 3) != 0 ? 1 : $urandom_range(1, 3),
                       $urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 1));
         end else if (r < 8) begin
            send_broken($urandom_range(0, 15), 8'($urandom), 16'($urandom_range(0, 40)),
                        $urandom_range(0, 1) ? 8'h11 : 8'($urandom));
         end else if (r == 8) begin
            send_tlv_case($urandom_range(0, 1) ? TLV_TYPE_TLS : 8'($urandom),
                          16'($urandom_range(0, 9)), $urandom_range(0, 6));
         end else begin
            send_byte(8'($urandom), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_backpressure();
      gap_tx_max = 0;
      stall_rx = 1'b1;
      fork
         send_frame(1, 1, 1, 20, 1);
         begin
            int c;
            c = 0;
            while (c < 150) begin @(posedge clock); c++; end
            stall_rx = 1'b0;
         end
      join
      gap_tx_max = 3;
   endtask

   // result checker
   always @(posedge clock) begin
      result_type got;
      result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[25:0]);
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h", rsp_tdata);
         end else begin
            exp = expected_beats.pop_front();
            if (got !== exp || rsp_tdata[31:26] !== 6'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", exp, rsp_tdata[25:0]);
            end
         end
      end
   end

   // receiver stalls
   initial begin
      int g;
      forever begin
         @(posedge clock);
         if (stall_rx) rsp_tready <= 1'b0;
         else begin
            g = pick_gap(gap_rx_max);
            if (g == 0) rsp_tready <= 1'b1;
            else begin
               rsp_tready <= 1'b0;
               repeat (g - 1) @(posedge clock);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      mark_en = 1'b1;
      clear_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_mark(1'b0);
      test_directed();
      test_random(150);
      write_mark(1'b1);
      test_backpressure();
      gap_tx_max = 0; gap_rx_max = 0;
      test_random(60);
      gap_tx_max = 3; gap_rx_max = 3;
      test_random(150);
      drain();
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/pv2_pkg.sv
rtl/pv2_front.sv
rtl/pv2_queue.sv
rtl/proxy_v2_header_parser.sv
tb/sv/tb.sv
